@@ rtl/core/sha256_hash_engine_defines.svh @@
// ----------------------------------------------------------------------------
// SHA-256 hash engine assertion macros
// Shared macros for the concurrent assertions of the engine's checker.
// ----------------------------------------------------------------------------
`ifndef SHA256_HASH_ENGINE_DEFINES_SVH
`define SHA256_HASH_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define SHA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/sha256_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-256 hash engine package
// Item types, SHA-256 constants and the round functions of the engine.
// ----------------------------------------------------------------------------
package sha256_pkg;

    // One input item: a message byte with its flags.
    typedef struct packed {
        logic [7:0] msg_byte;
        logic       byte_present;
        logic       end_of_message;
    } in_item_t;

    // One result item: the digest as four 64-bit words.
    typedef struct packed {
        logic [63:0] digest_word0;
        logic [63:0] digest_word1;
        logic [63:0] digest_word2;
        logic [63:0] digest_word3;
    } out_item_t;

    typedef logic [0:7][31:0] hash_set_t;

    // Padding constants and block positions.
    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;
    localparam logic [5:0] LAST_SLOT  = 6'd63;
    localparam logic [5:0] LAST_ROUND = 6'd63;

    // Initial hash values, H0 first.
    localparam hash_set_t INIT_HASH = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    // Round constants.
    localparam logic [31:0] ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    // Compression function sigma on the a word.
    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    // Compression function sigma on the e word.
    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    // Message schedule sigma on the word fifteen back.
    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    // Message schedule sigma on the word two back.
    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

@@ rtl/core/sha256_hash_engine.sv @@
// ----------------------------------------------------------------------------
// SHA-256 hash engine
// Byte-serial SHA-256 with one shared round unit under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
// Message items enter on msg_valid/msg_ready/msg_data, one byte per item.
// An item with byte_present low and end_of_message low is dropped. The item
// with end_of_message high closes the message (after its own byte, if any),
// and the engine then emits one digest item on dig_valid/dig_ready/dig_data.
// Flow: a byte item is taken while msg_ready is high. The 64th byte of a block
// starts the compression: the rounds, then a finishing step that folds the
// result into the hash words, during which msg_ready is low. An end item adds
// the padding, one byte per cycle up to the end of the block, and one or two
// more compressions; the digest is built in the finishing step after the last
// round and then registered at the output.
// Reset clears the hash words to the initial values and empties the block
// and bit count. The digest waits in an output register while dig_ready is
// low; byte items are still taken, but the next digest waits until the
// previous one has left.
// ----------------------------------------------------------------------------
module sha256_hash_engine (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  msg_valid,
    output logic                  msg_ready,
    input  sha256_pkg::in_item_t  msg_data,
    output logic                  dig_valid,
    input  logic                  dig_ready,
    output sha256_pkg::out_item_t dig_data
);

    typedef enum logic [2:0] {
        S_COLLECT,
        S_MARK,
        S_ZERO,
        S_ROUND,
        S_FINISH
    } state_t;

    state_t                state_reg, state_next;
    logic [511:0]          blk_reg, blk_next;
    logic [5:0]            fill_reg, fill_next;
    logic [63:0]           bc_reg, bc_next;
    logic [5:0]            round_reg, round_next;
    sha256_pkg::hash_set_t h_reg, h_next;
    sha256_pkg::hash_set_t v_reg, v_next;
    logic                  pad_reg, pad_next;
    logic                  len_reg, len_next;
    logic                  mark_reg, mark_next;
    logic                  out_valid_reg, out_valid_next;
    sha256_pkg::out_item_t out_data_reg, out_data_next;

    logic                  msg_fire;
    logic                  out_free;
    logic [31:0]           t1, t2, w_new;
    logic [7:0]            pad_byte;
    logic                  len_byte;
    sha256_pkg::hash_set_t h_sum;

    assign msg_ready = (state_reg == S_COLLECT);
    assign msg_fire  = msg_valid && msg_ready;
    assign out_free  = !out_valid_reg || dig_ready;
    assign dig_valid = out_valid_reg;
    assign dig_data  = out_data_reg;

    // Shared round unit: one compression round and one schedule word.
    always_comb
    begin
        t1 = v_reg[7] + sha256_pkg::big_sigma1(v_reg[4])
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + sha256_pkg::ROUND_K[round_reg] + blk_reg[511:480];
        t2 = sha256_pkg::big_sigma0(v_reg[0])
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        w_new = blk_reg[511:480] + sha256_pkg::small_sigma0(blk_reg[479:448])
              + blk_reg[223:192] + sha256_pkg::small_sigma1(blk_reg[63:32]);
    end

    // Hash words plus the working variables at the end of a block.
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            h_sum[i] = h_reg[i] + v_reg[i];
        end
    end

    // Padding byte: zeros, then the bit count high byte first in the last block.
    assign len_byte = len_reg && (fill_reg >= sha256_pkg::LEN_OFFSET);
    assign pad_byte = len_byte ? bc_reg[63:56] : 8'h00;

    // Sequencer next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        blk_next       = blk_reg;
        fill_next      = fill_reg;
        bc_next        = bc_reg;
        round_next     = round_reg;
        h_next         = h_reg;
        v_next         = v_reg;
        pad_next       = pad_reg;
        len_next       = len_reg;
        mark_next      = mark_reg;
        out_valid_next = out_valid_reg && !dig_ready;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            S_COLLECT:
            begin
                if (msg_fire)
                begin
                    if (msg_data.byte_present)
                    begin
                        blk_next  = {blk_reg[503:0], msg_data.msg_byte};
                        fill_next = fill_reg + 6'd1;
                        bc_next   = bc_reg + 64'd8;
                    end
                    if (msg_data.byte_present && fill_reg == sha256_pkg::LAST_SLOT)
                    begin
                        state_next = S_ROUND;
                        v_next     = h_reg;
                        round_next = 6'd0;
                        pad_next   = msg_data.end_of_message;
                        len_next   = 1'b0;
                        mark_next  = 1'b0;
                    end
                    else if (msg_data.end_of_message)
                    begin
                        state_next = S_MARK;
                        pad_next   = 1'b1;
                        mark_next  = 1'b0;
                    end
                end
            end

            S_MARK:
            begin
                blk_next  = {blk_reg[503:0], sha256_pkg::PAD_MARK};
                fill_next = fill_reg + 6'd1;
                mark_next = 1'b1;
                if (fill_reg == sha256_pkg::LAST_SLOT)
                begin
                    state_next = S_ROUND;
                    v_next     = h_reg;
                    round_next = 6'd0;
                    len_next   = 1'b0;
                end
                else
                begin
                    state_next = S_ZERO;
                    len_next   = (fill_reg < sha256_pkg::LEN_OFFSET);
                end
            end

            S_ZERO:
            begin
                blk_next  = {blk_reg[503:0], pad_byte};
                fill_next = fill_reg + 6'd1;
                if (len_byte)
                begin
                    bc_next = {bc_reg[55:0], 8'h00};
                end
                if (fill_reg == sha256_pkg::LAST_SLOT)
                begin
                    state_next = S_ROUND;
                    v_next     = h_reg;
                    round_next = 6'd0;
                end
            end

            S_ROUND:
            begin
                v_next     = {t1 + t2, v_reg[0], v_reg[1], v_reg[2],
                              v_reg[3] + t1, v_reg[4], v_reg[5], v_reg[6]};
                blk_next   = {blk_reg[479:0], w_new};
                round_next = round_reg + 6'd1;
                if (round_reg == sha256_pkg::LAST_ROUND)
                begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (!pad_reg)
                begin
                    h_next     = h_sum;
                    state_next = S_COLLECT;
                end
                else if (len_reg)
                begin
                    // Final block: hand out the digest once the output is free.
                    if (out_free)
                    begin
                        out_valid_next             = 1'b1;
                        out_data_next.digest_word0 = {h_sum[0], h_sum[1]};
                        out_data_next.digest_word1 = {h_sum[2], h_sum[3]};
                        out_data_next.digest_word2 = {h_sum[4], h_sum[5]};
                        out_data_next.digest_word3 = {h_sum[6], h_sum[7]};
                        h_next     = sha256_pkg::INIT_HASH;
                        bc_next    = 64'd0;
                        fill_next  = 6'd0;
                        pad_next   = 1'b0;
                        len_next   = 1'b0;
                        mark_next  = 1'b0;
                        state_next = S_COLLECT;
                    end
                end
                else if (!mark_reg)
                begin
                    h_next     = h_sum;
                    state_next = S_MARK;
                end
                else
                begin
                    h_next     = h_sum;
                    len_next   = 1'b1;
                    state_next = S_ZERO;
                end
            end

            default:
            begin
                state_next = S_COLLECT;
            end
        endcase
    end

    // State, datapath and output registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_COLLECT;
            fill_reg      <= 6'd0;
            bc_reg        <= 64'd0;
            round_reg     <= 6'd0;
            h_reg         <= sha256_pkg::INIT_HASH;
            pad_reg       <= 1'b0;
            len_reg       <= 1'b0;
            mark_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            bc_reg        <= bc_next;
            round_reg     <= round_next;
            h_reg         <= h_next;
            pad_reg       <= pad_next;
            len_reg       <= len_next;
            mark_reg      <= mark_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        blk_reg      <= blk_next;
        v_reg        <= v_next;
        out_data_reg <= out_data_next;
    end

endmodule

@@ rtl/core/sha256_checker.sv @@
// ----------------------------------------------------------------------------
// SHA-256 hash engine checker
// Port-level assertions on the engine, bound to its top level.
// ----------------------------------------------------------------------------
`include "sha256_hash_engine_defines.svh"

module sha256_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  msg_valid,
    input logic                  msg_ready,
    input sha256_pkg::in_item_t  msg_data,
    input logic                  dig_valid,
    input logic                  dig_ready,
    input sha256_pkg::out_item_t dig_data
);

    // A stalled digest item stays up with the same value.
    `SHA_ASSERT_NEXT(a_dig_hold, dig_valid && !dig_ready, dig_valid && $stable(dig_data), "digest item changed while stalled")

    // Once an end item is taken, padding or compression runs and no item is taken next cycle.
    `SHA_ASSERT_NEXT(a_end_busy, msg_valid && msg_ready && msg_data.end_of_message, !msg_ready, "input taken right after end item")

    // A new digest comes out of the finishing step, when input is held off.
    `SHA_ASSERT_NOW(a_dig_from_finish, $rose(dig_valid), !$past(msg_ready), "digest appeared while collecting bytes")

endmodule

bind sha256_hash_engine sha256_checker u_sha256_checker (.*);
